FILE: hdl/rotation_matrix_to_quaternion_defines.svh
// Assertion shorthands used by the top-level RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Whenever ante holds, cons holds in the same cycle.
`define RMQ_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// bad never holds.
`define RMQ_ASSERT_NEVER(name, clk, rstn, bad) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(bad)) \
    else $error("assertion failed: forbidden condition");

`endif

FILE: hdl/rmq_pkg.sv
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int IN_W          = 16;
  localparam int OUT_W         = 16;
  localparam int FRAC_BITS_DEF = 14;
  // normalized magnitudes: top bit of the largest at NORM_MSB
  localparam int NORM_MSB      = 27;
  localparam int NORM_W        = NORM_MSB + 1;
  localparam int RAD_W         = 2 * NORM_W + 2;
  localparam int ROOT_W        = RAD_W / 2;
  localparam int REM_W         = ROOT_W + 3;
  // side band through the root: degenerate, four signs, four magnitudes
  localparam int ROOT_SIDE_W   = 4 * NORM_W + 5;
  localparam int DIV_SIDE_W    = 5;

  typedef logic [3:0][NORM_W-1:0] norm4_t;

  typedef struct packed {
    logic signed [IN_W-1:0] i_basis_x;
    logic signed [IN_W-1:0] i_basis_y;
    logic signed [IN_W-1:0] i_basis_z;
    logic signed [IN_W-1:0] j_basis_x;
    logic signed [IN_W-1:0] j_basis_y;
    logic signed [IN_W-1:0] j_basis_z;
    logic signed [IN_W-1:0] k_basis_x;
    logic signed [IN_W-1:0] k_basis_y;
    logic signed [IN_W-1:0] k_basis_z;
  } mat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] quat_w;
    logic signed [OUT_W-1:0] quat_i;
    logic signed [OUT_W-1:0] quat_j;
    logic signed [OUT_W-1:0] quat_k;
    logic                    degenerate;
  } quat_t;

endpackage

FILE: hdl/rmq_if.sv
`timescale 1ns / 1ps

interface rmq_mat_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  mat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmq_quat_if;
  import rmq_pkg::*;
  logic  valid;
  logic  ready;
  quat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion (Shepperd's method), fixed point.
// mat_i: valid/ready request carrying the nine matrix elements, signed Q2.14
//   (Q2.FRAC_BITS), as basis columns i, j, k. quat_o: valid/ready request
//   with quaternion w, i, j, k in signed Q2.FRAC_BITS plus a degenerate flag
//   set when the root argument was not positive and got clamped to 1 LSB.
// Throughput: one request per cycle while quat_o is not held off.
// Pipeline: the front stages (branch select, magnitudes, normalize, squares)
//   feed the 29-stage bit-per-stage square root of the sum of squares and the
//   FRAC_BITS+2 stage divider that scales each component by the length.
// All stages advance together. When quat_o is held off (valid && !ready) the
//   whole pipeline freezes and mat_i.ready drops in the same cycle; nothing
//   is dropped or repeated, and it resumes the cycle ready returns.
// Reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_mat_if.sink   mat_i,
  rmq_quat_if.source quat_o
);
  import rmq_pkg::*;

  // signed width that holds every branch term and the root argument
  localparam int QW  = (FRAC_BITS > 16) ? FRAC_BITS + 2 : 19;
  localparam int MW  = $clog2(QW);
  localparam int QB  = FRAC_BITS + 1;
  localparam int OW  = (QB > 17) ? QB : 17;
  localparam int SHW = QW + NORM_MSB;
  localparam logic signed [QW-1:0] OneQ  = QW'(1) << FRAC_BITS;
  localparam logic [QB-1:0]        OneQb = QB'(1) << FRAC_BITS;

  // global advance: a frozen output freezes every stage
  logic en;
  logic acc;
  logic [7:0] fv_q;

  assign en          = !quat_o.valid || quat_o.ready;
  assign mat_i.ready = en;
  assign acc         = mat_i.valid && en;

  // ---- stage 1: branch select, root argument, unscaled quaternion ----
  logic signed [QW-1:0] ix, iy, iz, jx, jy, jz, kx, ky, kz;
  logic signed [QW-1:0] trace, r_raw, r_fix;
  logic                 use_tr, use_x, use_y, dg1_d;
  logic signed [QW-1:0] q1_d [4];
  logic signed [QW-1:0] q1_q [4];
  logic                 dg1_q;

  assign ix = QW'(mat_i.data.i_basis_x);
  assign iy = QW'(mat_i.data.i_basis_y);
  assign iz = QW'(mat_i.data.i_basis_z);
  assign jx = QW'(mat_i.data.j_basis_x);
  assign jy = QW'(mat_i.data.j_basis_y);
  assign jz = QW'(mat_i.data.j_basis_z);
  assign kx = QW'(mat_i.data.k_basis_x);
  assign ky = QW'(mat_i.data.k_basis_y);
  assign kz = QW'(mat_i.data.k_basis_z);

  always_comb begin
    trace  = ix + jy + kz;
    use_tr = trace > 0;
    // strict compares: ties fall through to the later diagonal
    use_x  = (ix > jy) && (ix > kz);
    use_y  = jy > kz;
    if (use_tr) begin
      r_raw = OneQ + trace;
    end else if (use_x) begin
      r_raw = OneQ + ix - jy - kz;
    end else if (use_y) begin
      r_raw = OneQ + jy - ix - kz;
    end else begin
      r_raw = OneQ + kz - ix - jy;
    end
    dg1_d = r_raw <= 0;
    r_fix = dg1_d ? QW'(1) : r_raw;
    if (use_tr) begin
      q1_d[0] = r_fix;   q1_d[1] = ky - jz; q1_d[2] = iz - kx; q1_d[3] = jx - iy;
    end else if (use_x) begin
      q1_d[0] = ky - jz; q1_d[1] = r_fix;   q1_d[2] = iy + jx; q1_d[3] = iz + kx;
    end else if (use_y) begin
      q1_d[0] = iz - kx; q1_d[1] = iy + jx; q1_d[2] = r_fix;   q1_d[3] = jz + ky;
    end else begin
      q1_d[0] = jx - iy; q1_d[1] = iz + kx; q1_d[2] = jz + ky; q1_d[3] = r_fix;
    end
  end

  // ---- stages 2..8: magnitudes, max, leading one, normalize, squares, sums ----
  logic [3:0][QW-1:0]         mag2_d;
  logic [3:0]                 ng2_d;
  logic [3:0][QW-1:0]         mag2_q, mag3_q, mag4_q;
  logic [3:0]                 ng2_q, ng3_q, ng4_q, ng5_q, ng6_q, ng7_q, ng8_q;
  logic                       dg2_q, dg3_q, dg4_q, dg5_q, dg6_q, dg7_q, dg8_q;
  logic [QW-1:0]              mxa, mxb, mx3_d, mx3_q;
  logic [MW-1:0]              msb4_d, msb4_q;
  logic [3:0][SHW-1:0]        wide;
  norm4_t                     nm5_d, nm5_q, nm6_q, nm7_q, nm8_q;
  logic [3:0][2*NORM_W-1:0]   sq6_d, sq6_q;
  logic [1:0][2*NORM_W:0]     ps7_d, ps7_q;
  logic [RAD_W-1:0]           sum8_d, sum8_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ng2_d[l]  = q1_q[l] < 0;
      mag2_d[l] = ng2_d[l] ? QW'(-q1_q[l]) : QW'(q1_q[l]);
    end
    mxa   = (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
    mxb   = (mag2_q[2] > mag2_q[3]) ? mag2_q[2] : mag2_q[3];
    mx3_d = (mxa > mxb) ? mxa : mxb;
    msb4_d = '0;
    for (int b = 0; b < QW; b++) begin
      if (mx3_q[b]) begin
        msb4_d = MW'(b);
      end
    end
    // common shift puts the largest magnitude's top bit at NORM_MSB
    for (int l = 0; l < 4; l++) begin
      wide[l]  = {mag4_q[l], {NORM_MSB{1'b0}}} >> msb4_q;
      nm5_d[l] = wide[l][NORM_W-1:0];
      sq6_d[l] = (2*NORM_W)'(nm5_q[l]) * (2*NORM_W)'(nm5_q[l]);
    end
    ps7_d[0] = (2*NORM_W+1)'(sq6_q[0]) + (2*NORM_W+1)'(sq6_q[1]);
    ps7_d[1] = (2*NORM_W+1)'(sq6_q[2]) + (2*NORM_W+1)'(sq6_q[3]);
    sum8_d   = RAD_W'(ps7_q[0]) + RAD_W'(ps7_q[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[6:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        q1_q[l] <= q1_d[l];
      end
      dg1_q  <= dg1_d;
      mag2_q <= mag2_d;  ng2_q <= ng2_d;  dg2_q <= dg1_q;
      mag3_q <= mag2_q;  ng3_q <= ng2_q;  dg3_q <= dg2_q;  mx3_q <= mx3_d;
      mag4_q <= mag3_q;  ng4_q <= ng3_q;  dg4_q <= dg3_q;  msb4_q <= msb4_d;
      nm5_q  <= nm5_d;   ng5_q <= ng4_q;  dg5_q <= dg4_q;
      sq6_q  <= sq6_d;   nm6_q <= nm5_q;  ng6_q <= ng5_q;  dg6_q <= dg5_q;
      ps7_q  <= ps7_d;   nm7_q <= nm6_q;  ng7_q <= ng6_q;  dg7_q <= dg6_q;
      sum8_q <= sum8_d;  nm8_q <= nm7_q;  ng8_q <= ng7_q;  dg8_q <= dg7_q;
    end
  end

  // ---- length: floor sqrt of the sum of squares ----
  logic                    sq_valid;
  logic [ROOT_W-1:0]       sq_len;
  logic [ROOT_SIDE_W-1:0]  sq_side;
  norm4_t                  sq_mag;
  logic [3:0]              sq_ng;
  logic                    sq_dg;

  rmq_isqrt #(
    .SIDE_W (ROOT_SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv_q[7]),
    .rad_i   (sum8_q),
    .side_i  ({dg8_q, ng8_q, nm8_q}),
    .valid_o (sq_valid),
    .root_o  (sq_len),
    .side_o  (sq_side)
  );

  assign {sq_dg, sq_ng, sq_mag} = sq_side;

  // ---- scale each magnitude by 1/length ----
  logic                    dv_valid;
  logic [3:0][QB-1:0]      dv_quo;
  logic [DIV_SIDE_W-1:0]   dv_side;
  logic [3:0]              dv_ng;
  logic                    dv_dg;

  rmq_div #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (DIV_SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .mag_i   (sq_mag),
    .len_i   (sq_len),
    .side_i  ({sq_dg, sq_ng}),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  assign {dv_dg, dv_ng} = dv_side;

  // ---- sign and saturate to 16 bits ----
  logic [OW-1:0]                mz [4];
  logic [OW-1:0]                mn [4];
  logic [3:0][OUT_W-1:0]        ov;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mz[l] = OW'(dv_quo[l]);
      mn[l] = OW'(0) - mz[l];
      if (dv_ng[l]) begin
        ov[l] = (mz[l] > OW'(32768)) ? OUT_W'(16'h8000) : mn[l][OUT_W-1:0];
      end else begin
        ov[l] = (mz[l] > OW'(32767)) ? OUT_W'(16'h7fff) : mz[l][OUT_W-1:0];
      end
    end
  end

  assign quat_o.valid           = dv_valid;
  assign quat_o.data.quat_w     = ov[0];
  assign quat_o.data.quat_i     = ov[1];
  assign quat_o.data.quat_j     = ov[2];
  assign quat_o.data.quat_k     = ov[3];
  assign quat_o.data.degenerate = dv_dg;

  // ---- checks ----
  // a held-off result must freeze the input side
  `RMQ_ASSERT_IMPL(a_stall_blocks_input, clk_i, rst_ni, quat_o.valid && !quat_o.ready, !mat_i.ready)
  // largest normalized magnitude is at least 2^NORM_MSB, so length never drops below it
  `RMQ_ASSERT_NEVER(a_len_floor, clk_i, rst_ni, sq_valid && (sq_len[ROOT_W-1:NORM_MSB] == '0))
  // a unit quaternion component never exceeds one
  `RMQ_ASSERT_NEVER(a_unit_bound, clk_i, rst_ni, dv_valid && ((dv_quo[0] > OneQb) || (dv_quo[1] > OneQb) || (dv_quo[2] > OneQb) || (dv_quo[3] > OneQb)))

endmodule

FILE: hdl/rmq_isqrt.sv
`timescale 1ns / 1ps

// Pipelined floor square root, one result bit per stage.
module rmq_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rmq_pkg::RAD_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [rmq_pkg::ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]           side_o
);
  import rmq_pkg::*;

  logic [ROOT_W-1:0] v_q;
  logic [ROOT_W-1:0] v_d;
  logic [RAD_W-1:0]  rad_q [ROOT_W];
  logic [RAD_W-1:0]  rad_in [ROOT_W];
  logic [REM_W-1:0]  rem_q [ROOT_W];
  logic [REM_W-1:0]  rem_in [ROOT_W];
  logic [REM_W-1:0]  rem_n [ROOT_W];
  logic [REM_W-1:0]  trial [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];
  logic [SIDE_W-1:0] side_in [ROOT_W];
  logic [ROOT_W-1:0] ge;

  assign v_d = {v_q[ROOT_W-2:0], valid_i};

  always_comb begin
    rad_in[0]  = rad_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    side_in[0] = side_i;
    for (int k = 1; k < ROOT_W; k++) begin
      rad_in[k]  = rad_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      side_in[k] = side_q[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      // bring down the next two radicand bits, try (2*root)*2+1
      rem_n[k] = {rem_in[k][REM_W-3:0], rad_in[k][RAD_W-1 -: 2]};
      trial[k] = {1'b0, root_in[k], 2'b01};
      ge[k]    = rem_n[k] >= trial[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rad_q[k]  <= rad_in[k] << 2;
        rem_q[k]  <= ge[k] ? (rem_n[k] - trial[k]) : rem_n[k];
        root_q[k] <= {root_in[k][ROOT_W-2:0], ge[k]};
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

FILE: hdl/rmq_div.sv
`timescale 1ns / 1ps

// Four-lane pipelined rounded divide: quo = (mag * 2^FRAC_BITS + len/2) / len.
// One numerator stage, then one quotient bit per stage. Requires mag <= len.
module rmq_div #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  rmq_pkg::norm4_t               mag_i,
  input  logic [rmq_pkg::ROOT_W-1:0]    len_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [3:0][FRAC_BITS:0]       quo_o,
  output logic [SIDE_W-1:0]             side_o
);
  import rmq_pkg::*;

  localparam int QB = FRAC_BITS + 1;
  localparam int NW = NORM_W + FRAC_BITS + 1;
  localparam int DR = ROOT_W + 1;
  localparam int NS = QB + 1;

  logic [NS-1:0]            v_q;
  logic [NS-1:0]            v_d;
  logic [3:0][NW-1:0]       num;
  logic [3:0][DR-1:0]       rem_q [NS];
  logic [3:0][QB-1:0]       lo_q [NS];
  logic [3:0][QB-1:0]       quo_q [NS];
  logic [ROOT_W-1:0]        len_q [NS];
  logic [SIDE_W-1:0]        side_q [NS];
  logic [3:0][DR-1:0]       rem_n [NS];
  logic [3:0]               ge [NS];

  assign v_d = {v_q[NS-2:0], valid_i};

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      num[l] = (NW'(mag_i[l]) << FRAC_BITS) + NW'(len_i >> 1);
    end
    rem_n[0] = '0;
    ge[0]    = '0;
    for (int k = 1; k < NS; k++) begin
      for (int l = 0; l < 4; l++) begin
        rem_n[k][l] = {rem_q[k-1][l][DR-2:0], lo_q[k-1][l][QB-1]};
        ge[k][l]    = rem_n[k][l] >= DR'(len_q[k-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // numerator stage: high part is already below len
      for (int l = 0; l < 4; l++) begin
        rem_q[0][l] <= DR'(num[l][NW-1:QB]);
        lo_q[0][l]  <= num[l][QB-1:0];
        quo_q[0][l] <= '0;
      end
      len_q[0]  <= len_i;
      side_q[0] <= side_i;
      for (int k = 1; k < NS; k++) begin
        for (int l = 0; l < 4; l++) begin
          rem_q[k][l] <= ge[k][l] ? (rem_n[k][l] - DR'(len_q[k-1])) : rem_n[k][l];
          lo_q[k][l]  <= lo_q[k-1][l] << 1;
          quo_q[k][l] <= {quo_q[k-1][l][QB-2:0], ge[k][l]};
        end
        len_q[k]  <= len_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

FILE: tb/sv/tb_rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 8 + 29 + FRAC + 2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rmq_mat_if  mat_if ();
  rmq_quat_if quat_if ();

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mat_i  (mat_if.sink),
    .quat_o (quat_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  quat_t expected_quats[$];
  int    mismatch_count = 0;
  bit    sink_idle_en = 1'b1;   // random holdoff on the result side
  bit    src_idle_en  = 1'b1;   // random gaps between requests
  int    sink_hold_cycles = 0;  // long forced holdoff, counted down

  // Bitwise integer square root, floor.
  function automatic longint unsigned sqrt_floor(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Shepperd branch pick, common-shift normalization, rounded division.
  function automatic quat_t matrix_to_quat(input mat_t m);
    longint ix, iy, iz, jx, jy, jz, kx, ky, kz, tr, r;
    longint q[4];
    longint unsigned mag[4];
    longint unsigned mx, sum, len, quo;
    int    msb;
    int    br;
    bit    degen;
    logic signed [15:0] o[4];
    quat_t res;
    ix = m.i_basis_x; iy = m.i_basis_y; iz = m.i_basis_z;
    jx = m.j_basis_x; jy = m.j_basis_y; jz = m.j_basis_z;
    kx = m.k_basis_x; ky = m.k_basis_y; kz = m.k_basis_z;
    tr = ix + jy + kz;
    degen = 1'b0;
    if (tr > 0) begin
      br = 0; r = (64'sd1 <<< FRAC) + tr;
    end else if (ix > jy && ix > kz) begin
      br = 1; r = (64'sd1 <<< FRAC) + ix - jy - kz;
    end else if (jy > kz) begin
      br = 2; r = (64'sd1 <<< FRAC) + jy - ix - kz;
    end else begin
      br = 3; r = (64'sd1 <<< FRAC) + kz - ix - jy;
    end
    if (r <= 0) begin
      r = 1; degen = 1'b1;
    end
    case (br)
      0: begin q[0] = r; q[1] = ky - jz; q[2] = iz - kx; q[3] = jx - iy; end
      1: begin q[0] = ky - jz; q[1] = r; q[2] = iy + jx; q[3] = iz + kx; end
      2: begin q[0] = iz - kx; q[1] = iy + jx; q[2] = r; q[3] = jz + ky; end
      default: begin q[0] = jx - iy; q[1] = iz + kx; q[2] = jz + ky; q[3] = r; end
    endcase
    mx = 0;
    for (int k = 0; k < 4; k++) begin
      mag[k] = (q[k] < 0) ? -q[k] : q[k];
      if (mag[k] > mx) mx = mag[k];
    end
    msb = 0;
    while (msb < 63 && (mx >> (msb + 1)) != 0) msb++;
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      if (msb > NORM_MSB) mag[k] = mag[k] >> (msb - NORM_MSB);
      else mag[k] = mag[k] << (NORM_MSB - msb);
      sum += mag[k] * mag[k];
    end
    len = sqrt_floor(sum);
    if (len == 0) begin
      len = 1; degen = 1'b1;
    end
    for (int k = 0; k < 4; k++) begin
      quo = (mag[k] * (64'd1 << FRAC) + (len >> 1)) / len;
      if (q[k] < 0) o[k] = (quo > 32768) ? -16'sd32768 : 16'(-quo);
      else o[k] = (quo > 32767) ? 16'sd32767 : 16'(quo);
    end
    res.quat_w = o[0]; res.quat_i = o[1]; res.quat_j = o[2]; res.quat_k = o[3];
    res.degenerate = degen;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Send one request; gaps come in random bursts ahead of it.
  // valid stays high after the accept so the next request can follow directly.
  task automatic send_matrix(input mat_t m);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      mat_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mat_if.valid <= 1'b1;
    mat_if.data  <= m;
    @(posedge clk_i);
    while (!mat_if.ready) @(posedge clk_i);
    expected_quats.push_back(matrix_to_quat(m));
  endtask

  // Result side ready: random bursts of holdoff, or a long forced stall.
  initial begin
    int burst;
    quat_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold_cycles > 0) begin
        quat_if.ready <= 1'b0;
        sink_hold_cycles--;
      end else if (sink_idle_en && burst == 0 && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 10);
        quat_if.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        quat_if.ready <= (burst == 0);
      end else begin
        quat_if.ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    quat_t got, want;
    if (rst_ni && quat_if.valid && quat_if.ready) begin
      got = quat_if.data;
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_quats.pop_front();
        if (got.quat_w !== want.quat_w)
          report_mismatch("quat_w", int'(got.quat_w), int'(want.quat_w));
        if (got.quat_i !== want.quat_i)
          report_mismatch("quat_i", int'(got.quat_i), int'(want.quat_i));
        if (got.quat_j !== want.quat_j)
          report_mismatch("quat_j", int'(got.quat_j), int'(want.quat_j));
        if (got.quat_k !== want.quat_k)
          report_mismatch("quat_k", int'(got.quat_k), int'(want.quat_k));
        if (got.degenerate !== want.degenerate)
          report_mismatch("degenerate", int'(got.degenerate), int'(want.degenerate));
      end
    end
  end

  function automatic mat_t make_mat(input int ix, iy, iz, jx, jy, jz, kx, ky, kz);
    mat_t m;
    m.i_basis_x = IN_W'(ix); m.i_basis_y = IN_W'(iy); m.i_basis_z = IN_W'(iz);
    m.j_basis_x = IN_W'(jx); m.j_basis_y = IN_W'(jy); m.j_basis_z = IN_W'(jz);
    m.k_basis_x = IN_W'(kx); m.k_basis_y = IN_W'(ky); m.k_basis_z = IN_W'(kz);
    return m;
  endfunction

  function automatic mat_t random_mat();
    logic [159:0] raw;
    mat_t m;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    m = raw[$bits(mat_t)-1:0];
    return m;
  endfunction

  // Near-rotation: random signed cyclic permutation with small noise, so every
  // branch shows up with well-formed content.
  function automatic mat_t rotation_like_mat();
    int e[9];
    int p;
    int one;
    one = 1 << FRAC;
    for (int k = 0; k < 9; k++) e[k] = $urandom_range(0, 2 * one / 3) - one / 3;
    p = $urandom_range(0, 2);
    for (int c = 0; c < 3; c++)
      e[c * 3 + (c + p) % 3] = ($urandom_range(0, 1) ? one : -one)
                               + $urandom_range(0, 600) - 300;
    return make_mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
  endfunction

  task automatic test_directed();
    int one;
    one = 1 << FRAC;
    send_matrix(make_mat(one, 0, 0, 0, one, 0, 0, 0, one));          // identity
    send_matrix(make_mat(one, 0, 0, 0, -one, 0, 0, 0, -one));        // x largest
    send_matrix(make_mat(-one, 0, 0, 0, one, 0, 0, 0, -one));        // y largest
    send_matrix(make_mat(-one, 0, 0, 0, -one, 0, 0, 0, one));        // z largest
    send_matrix(make_mat(0, one, 0, -one, 0, 0, 0, 0, one));         // z turn
    send_matrix(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));                // zero trace tie
    send_matrix(make_mat(-one, 0, 0, 0, -one, 0, 0, 0, -one));       // diagonal tie
    send_matrix(make_mat(-5, 0, 0, 0, -5, 0, 0, 0, -9));             // x, y tie
    send_matrix(make_mat(-32768, 0, 0, 0, 32767, 0, 0, 0, 32767));   // extreme diagonal, trace branch
    send_matrix(make_mat(-32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768));
    send_matrix(make_mat(32767, 32767, 32767, 32767, 32767, 32767,
                         32767, 32767, 32767));
    send_matrix(make_mat(32767, -32768, 32767, -32768, 32767, -32768,
                         32767, -32768, 32767));
    send_matrix(make_mat(-32768, 32767, -32768, 32767, -32768, 32767,
                         -32768, 32767, -32768));
    send_matrix(make_mat(1, 0, 0, 0, 0, 0, 0, 0, 0));                // smallest trace
    send_matrix(make_mat(-20000, 30000, -30000, -30000, -20000, 30000,
                         30000, -30000, -20000));
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) send_matrix(random_mat());
      else send_matrix(rotation_like_mat());
    end
  endtask

  // Long result-side stall while requests keep coming: pipeline fills.
  task automatic test_backpressure();
    sink_hold_cycles = 3 * LATENCY;
    for (int n = 0; n < 2 * LATENCY; n++) send_matrix(rotation_like_mat());
  endtask

  task automatic test_full_rate(input int count);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int n = 0; n < count; n++) send_matrix(rotation_like_mat());
  endtask

  initial begin
    mat_if.valid <= 1'b0;
    mat_if.data  <= '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450);
    test_backpressure();
    test_full_rate(130);
    mat_if.valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_quats.size() == 0) begin
      $display("** rotation_matrix_to_quaternion: PASSED **");
    end else begin
      $display("** rotation_matrix_to_quaternion: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** rotation_matrix_to_quaternion: FAILED **");
    $finish;
  end

endmodule

FILE: rotation_matrix_to_quaternion.f
+incdir+hdl
hdl/rmq_pkg.sv
hdl/rmq_if.sv
hdl/rmq_isqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion.sv
tb/sv/tb_rotation_matrix_to_quaternion.sv
